>>> rtl/fisr_pkg.sv
`timescale 1ns / 1ps
// fisr_pkg: types, constants and float helpers for the fast inverse square root pipeline.
// No dependencies.
package fisr_pkg;

   localparam logic [31:0] SEED_MAGIC = 32'h5f3759df;
   localparam logic [31:0] CANON_NAN  = 32'h7FC00000;
   localparam logic [31:0] ONE_HALF   = 32'h3F000000;
   localparam logic [31:0] THREE_HALF = 32'h3FC00000;

   typedef logic [31:0] fp_type;

   // first half of a multiply: unpacked operands and product
   typedef struct packed {
      logic        sign;
      logic        is_nan;
      logic        is_inf;
      logic        is_zero;
      logic signed [10:0] exp;
      logic [47:0] prod;
   } mul_mid_type;

   // round and pack: value = m_in * 2^(e_in-47) nominally; m_in need not be normalized
   function automatic fp_type round_pack(input logic sign, input logic signed [10:0] e_in,
                                         input logic [49:0] m_in);
      logic [5:0]  lz;
      logic signed [11:0] e;
      logic [49:0] m;
      logic [49:0] sh;
      logic [24:0] mant;
      logic        g, st;
      logic [11:0] rs;
      fp_type      r;
      lz = 6'd0;
      for (int i = 49; i >= 0; i--) begin
         if (m_in[i] && lz == 6'd0) lz = 6'(49 - i);
      end
      // value = m_in * 2^(e_in - 47); normalized msb to bit 49
      m = m_in << lz;
      e = 12'(e_in) + 12'sd2 - 12'(signed'({1'b0, lz}));
      // e is the biased exponent for the normalized value with msb at 49
      if (e < 12'sd1) begin
         rs = 12'sd1 - e;
         if (rs > 12'd50) rs = 12'd50;
         sh = m >> rs[5:0];
         st = |(m & ~({50{1'b1}} << rs[5:0]));
         e  = 12'sd0;
         m  = sh;
      end else begin
         st = 1'b0;
      end
      mant = {1'b0, m[49:26]};
      g    = m[25];
      st   = st | (|m[24:0]);
      if (g && (st || mant[0])) mant = mant + 25'd1;
      if (mant[24]) begin
         mant = mant >> 1;
         e = e + 12'sd1;
      end else if (e == 12'sd0 && mant[23]) begin
         e = 12'sd1;
      end
      if (e >= 12'sd255) r = {sign, 8'hFF, 23'd0};
      else r = {sign, e[7:0], mant[22:0]};
      return r;
   endfunction

endpackage

>>> rtl/fisr_fmul.sv
`timescale 1ns / 1ps
// fisr_fmul: two-stage pipelined binary32 multiply, round to nearest even.
// Depends on fisr_pkg.
module fisr_fmul (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_in,
   input  fisr_pkg::fp_type     a,
   input  fisr_pkg::fp_type     b,
   input  logic [31:0]          side_in,
   output logic                 valid_out,
   output fisr_pkg::fp_type     y,
   output logic [31:0]          side_out
);
   fisr_pkg::mul_mid_type mid_ff, mid_in;
   logic [31:0] side_mid_ff, side_ff;
   logic v_mid_ff, v_ff;
   fisr_pkg::fp_type y_ff, y_in;

   always_comb begin
      logic ae0, be0, an, bn, ai, bi, az, bz;
      ae0 = a[30:23] == 8'd0;
      be0 = b[30:23] == 8'd0;
      an = a[30:23] == 8'hFF && a[22:0] != 23'd0;
      bn = b[30:23] == 8'hFF && b[22:0] != 23'd0;
      ai = a[30:23] == 8'hFF && a[22:0] == 23'd0;
      bi = b[30:23] == 8'hFF && b[22:0] == 23'd0;
      az = a[30:0] == 31'd0;
      bz = b[30:0] == 31'd0;
      mid_in.sign    = a[31] ^ b[31];
      mid_in.is_nan  = an || bn || (ai && bz) || (bi && az);
      mid_in.is_inf  = ai || bi;
      mid_in.is_zero = az || bz;
      mid_in.exp     = 11'(signed'({3'b0, ae0 ? 8'd1 : a[30:23]}))
                     + 11'(signed'({3'b0, be0 ? 8'd1 : b[30:23]})) - 11'sd127;
      mid_in.prod    = {!ae0, a[22:0]} * {!be0, b[22:0]};
   end

   // product bit 46 is the unit position for exp, round_pack expects it at bit 47
   always_comb begin
      if (mid_ff.is_nan) y_in = fisr_pkg::CANON_NAN;
      else if (mid_ff.is_inf) y_in = {mid_ff.sign, 8'hFF, 23'd0};
      else if (mid_ff.is_zero || mid_ff.prod == 48'd0) y_in = {mid_ff.sign, 31'd0};
      else y_in = fisr_pkg::round_pack(mid_ff.sign, mid_ff.exp, {1'b0, mid_ff.prod, 1'b0});
   end

   always_ff @(posedge clock) begin
      mid_ff      <= mid_in;
      side_mid_ff <= side_in;
      y_ff        <= y_in;
      side_ff     <= side_mid_ff;
      if (reset) begin
         v_mid_ff <= 1'b0;
         v_ff     <= 1'b0;
      end else begin
         v_mid_ff <= valid_in;
         v_ff     <= v_mid_ff;
      end
   end

   assign valid_out = v_ff;
   assign y         = y_ff;
   assign side_out  = side_ff;
endmodule

>>> rtl/fisr_fsub.sv
`timescale 1ns / 1ps
// fisr_fsub: two-stage pipelined 1.5 - t in binary32, round to nearest even.
// Depends on fisr_pkg.
module fisr_fsub (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_in,
   input  fisr_pkg::fp_type     t,
   input  logic [31:0]          side_in,
   output logic                 valid_out,
   output fisr_pkg::fp_type     y,
   output logic [31:0]          side_out
);
   // align stage
   logic        sgn_ff, sgn_in, spec_ff, spec_in;
   logic signed [10:0] e_ff, e_in;
   logic [49:0] m_ff, m_in;
   fisr_pkg::fp_type spec_val_ff, spec_val_in;
   logic [31:0] side_mid_ff, side_ff;
   logic v_mid_ff, v_ff;
   fisr_pkg::fp_type y_ff, y_in;

   always_comb begin
      logic [7:0]  te;
      logic [23:0] tm;
      logic [7:0]  ea, eb;
      logic [23:0] ma, mb;
      logic        sb;
      logic [7:0]  d;
      logic [75:0] wa, wb, ws;
      logic        sticky;
      te = t[30:23];
      tm = {te != 8'd0, t[22:0]};
      // operand a = +1.5, operand b = -t
      sb = !t[31];
      spec_in = 1'b0;
      spec_val_in = '0;
      if (te == 8'hFF) begin
         spec_in = 1'b1;
         spec_val_in = (t[22:0] != 23'd0) ? fisr_pkg::CANON_NAN : {sb, 8'hFF, 23'd0};
      end
      // order by magnitude
      if ({te, t[22:0]} > fisr_pkg::THREE_HALF[30:0]) begin
         ea = (te == 8'd0) ? 8'd1 : te; ma = tm;
         eb = 8'd127; mb = 24'hC00000;
         sgn_in = sb;
         sb = 1'b0;
      end else begin
         ea = 8'd127; ma = 24'hC00000;
         eb = (te == 8'd0) ? 8'd1 : te; mb = tm;
         sgn_in = 1'b0;
      end
      d = ea - eb;
      wa = {2'b0, ma, 50'd0};
      wb = {2'b0, mb, 50'd0};
      if (d > 8'd74) begin
         sticky = mb != 24'd0;
         wb = '0;
      end else begin
         sticky = |(wb & ~({76{1'b1}} << d));
         wb = wb >> d;
      end
      if (sb == sgn_in) ws = wa + wb;
      else ws = wa - wb - 76'(sticky);
      // keep top 50 bits, fold remainder into lsb
      m_in = {ws[75:27], ws[26] | (|ws[25:0]) | sticky};
      // msb of ma sits at bit 73 of ws -> bit 47 of m_in when exp = ea
      e_in = 11'(signed'({3'b0, ea}));
      if (ws == 76'd0 && !sticky) sgn_in = 1'b0;
   end

   always_comb begin
      if (spec_ff) y_in = spec_val_ff;
      else if (m_ff == 50'd0) y_in = {sgn_ff, 31'd0};
      else y_in = fisr_pkg::round_pack(sgn_ff, e_ff, m_ff);
   end

   always_ff @(posedge clock) begin
      sgn_ff      <= sgn_in;
      spec_ff     <= spec_in;
      spec_val_ff <= spec_val_in;
      e_ff        <= e_in;
      m_ff        <= m_in;
      side_mid_ff <= side_in;
      y_ff        <= y_in;
      side_ff     <= side_mid_ff;
      if (reset) begin
         v_mid_ff <= 1'b0;
         v_ff     <= 1'b0;
      end else begin
         v_mid_ff <= valid_in;
         v_ff     <= v_mid_ff;
      end
   end

   assign valid_out = v_ff;
   assign y         = y_ff;
   assign side_out  = side_ff;
endmodule

>>> rtl/fisr_newton.sv
`timescale 1ns / 1ps
// fisr_newton: one Newton step y*(1.5 - (x2*y)*y) as a chain of pipelined units.
// Depends on fisr_pkg, fisr_fmul, fisr_fsub.
module fisr_newton (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_in,
   input  fisr_pkg::fp_type     x2_in,
   input  fisr_pkg::fp_type     y_in,
   output logic                 valid_out,
   output fisr_pkg::fp_type     x2_out,
   output fisr_pkg::fp_type     y_out
);
   logic v1, v2, v3;
   fisr_pkg::fp_type t1, t2, t3, s1, s2, s3;
   logic [31:0] x4;

   // y travels through the side channels of the first three units, x2 through the last one's
   fisr_fmul u_m1 (.clock, .reset, .valid_in, .a(x2_in), .b(y_in), .side_in(y_in),
                   .valid_out(v1), .y(t1), .side_out(s1));
   fisr_fmul u_m2 (.clock, .reset, .valid_in(v1), .a(t1), .b(s1), .side_in(s1),
                   .valid_out(v2), .y(t2), .side_out(s2));
   fisr_fsub u_s  (.clock, .reset, .valid_in(v2), .t(t2), .side_in(s2),
                   .valid_out(v3), .y(t3), .side_out(s3));
   fisr_fmul u_m3 (.clock, .reset, .valid_in(v3), .a(s3), .b(t3), .side_in(x4),
                   .valid_out(valid_out), .y(y_out), .side_out(x2_out));

   // x2 delay line, six stages to match the first three units
   logic [31:0] xd_ff [6];
   always_ff @(posedge clock) begin
      xd_ff[0] <= x2_in;
      for (int i = 1; i < 6; i++) xd_ff[i] <= xd_ff[i-1];
   end
   assign x4 = xd_ff[5];
endmodule

>>> rtl/fast_inverse_sqrt_float.sv
`timescale 1ns / 1ps
// Fast inverse square root, binary32 in and out, one transaction per cycle.
// Pipeline: a front multiply by 0.5, then per step three multiplies and one subtract
// of two stages each. Throughput 1 per cycle.
// busy is always low; reset clears only valid bits, payload is not reset.
// Depends on fisr_pkg, fisr_fmul, fisr_newton.
module fast_inverse_sqrt_float #(
   parameter int NEWTON_STEPS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_number_bits,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_bits
);
   logic                 v [NEWTON_STEPS+1];
   fisr_pkg::fp_type     x [NEWTON_STEPS+1];
   fisr_pkg::fp_type     y [NEWTON_STEPS+1];
   logic [31:0]          seed;

   assign busy = 1'b0;
   assign seed = fisr_pkg::SEED_MAGIC - {1'b0, req_number_bits[31:1]};

   fisr_fmul u_half (.clock, .reset, .valid_in(start), .a(req_number_bits),
                     .b(fisr_pkg::ONE_HALF), .side_in(seed),
                     .valid_out(v[0]), .y(x[0]), .side_out(y[0]));

   for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
      fisr_newton u_step (.clock, .reset, .valid_in(v[k]), .x2_in(x[k]), .y_in(y[k]),
                          .valid_out(v[k+1]), .x2_out(x[k+1]), .y_out(y[k+1]));
   end

   assign rsp_valid = v[NEWTON_STEPS];
   assign rsp_result_bits = (y[NEWTON_STEPS][30:23] == 8'hFF && y[NEWTON_STEPS][22:0] != 23'd0)
                          ? fisr_pkg::CANON_NAN : y[NEWTON_STEPS];
endmodule

>>> rtl/fisr_checker.sv
`timescale 1ns / 1ps
// fisr_checker: port-level assertions for fast_inverse_sqrt_float, bound to the top.
// Depends on fast_inverse_sqrt_float ports only.
module fisr_checker #(
   parameter int NEWTON_STEPS = 3
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_result_bits
);
   localparam int LAT = 2 + 8 * NEWTON_STEPS;

   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result without transaction");
   a_canon_nan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_bits[30:23] == 8'hFF) |->
      (rsp_result_bits[22:0] == 23'd0 || rsp_result_bits == 32'h7FC00000))
      else $error("non canonical NaN");
endmodule

bind fast_inverse_sqrt_float fisr_checker #(.NEWTON_STEPS(NEWTON_STEPS)) u_fisr_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_result_bits);

>>> dv/fast_inverse_sqrt_float_tb.sv
`timescale 1ns / 1ps
// Testbench for fast_inverse_sqrt_float: random and directed binary32 stimulus, results checked
// against a bit-exact software rsqrt model held in a scoreboard class.
// Depends on fisr_pkg and the fast_inverse_sqrt_float RTL.
module fast_inverse_sqrt_float_tb;

   localparam int STEPS      = 3;
   localparam int LATENCY    = 2 + 8 * STEPS;
   localparam int N_RANDOM   = 650;
   localparam int STALL_MAX  = 2000;
   localparam logic [31:0] F_POS_INF = 32'h7F800000;

   class rsqrt_scoreboard;
      fisr_pkg::fp_type pending_q[$];
      int     mismatches;

      // round m * 2^e to binary32, nearest-even, with subnormals and overflow
      static function fisr_pkg::fp_type round_rne(logic sgn, int e, logic [69:0] m);
         int msb, s, be;
         logic [69:0] mant;
         logic g, st;
         if (m == 0) return {sgn, 31'd0};
         msb = 0;
         for (int i = 0; i < 70; i++) if (m[i]) msb = i;
         s = msb - 23;
         if (s < -149 - e) s = -149 - e;
         g  = 1'b0;
         st = 1'b0;
         if (s <= 0) mant = m << (-s);
         else begin
            mant = m >> s;
            g = m[s - 1];
            for (int i = 0; i < s - 1; i++) st |= m[i];
         end
         if (g && (st || mant[0])) mant = mant + 1;
         if (mant[24]) begin
            mant = mant >> 1;
            s = s + 1;
         end
         if (!mant[23]) return {sgn, 8'd0, mant[22:0]};
         be = e + s + 150;
         if (be >= 255) return {sgn, F_POS_INF[30:0]};
         return {sgn, 8'(be), mant[22:0]};
      endfunction

      static function void split(fisr_pkg::fp_type v, output logic [23:0] m, output int e);
         if (v[30:23] == 0) begin
            m = {1'b0, v[22:0]};
            e = -149;
         end else begin
            m = {1'b1, v[22:0]};
            e = int'(v[30:23]) - 150;
         end
      endfunction

      static function logic is_nan(fisr_pkg::fp_type v);
         return v[30:23] == 8'hFF && v[22:0] != 0;
      endfunction

      static function logic is_inf(fisr_pkg::fp_type v);
         return v[30:0] == F_POS_INF[30:0];
      endfunction

      static function fisr_pkg::fp_type fmul(fisr_pkg::fp_type a, fisr_pkg::fp_type b);
         logic [23:0] ma, mb;
         int ea, eb;
         logic sgn;
         sgn = a[31] ^ b[31];
         if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_NAN;
         if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0))
            return fisr_pkg::CANON_NAN;
         if (is_inf(a) || is_inf(b)) return {sgn, F_POS_INF[30:0]};
         split(a, ma, ea);
         split(b, mb, eb);
         return round_rne(sgn, ea + eb, 70'(ma) * 70'(mb));
      endfunction

      static function fisr_pkg::fp_type fsub(fisr_pkg::fp_type a, fisr_pkg::fp_type b);
         logic [23:0] ma, mb, mt;
         int ea, eb, et, d, e;
         logic sa, sb, ts;
         logic [69:0] big, lil, m;
         sa = a[31];
         sb = ~b[31];
         if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_NAN;
         if (is_inf(a) && is_inf(b)) return (sa == sb) ? a : fisr_pkg::CANON_NAN;
         if (is_inf(a)) return a;
         if (is_inf(b)) return {sb, b[30:0]};
         split(a, ma, ea);
         split(b, mb, eb);
         if (ea < eb) begin
            mt = ma; ma = mb; mb = mt;
            et = ea; ea = eb; eb = et;
            ts = sa; sa = sb; sb = ts;
         end
         d = ea - eb;
         if (d > 40) begin
            big = 70'(ma) << 40;
            lil = 70'(mb != 0);
            e   = ea - 40;
         end else begin
            big = 70'(ma) << d;
            lil = 70'(mb);
            e   = eb;
         end
         if (sa == sb) return round_rne(sa, e, big + lil);
         if (big == lil) return {sa & sb, 31'd0};
         if (big > lil) return round_rne(sa, e, big - lil);
         return round_rne(sb, e, lil - big);
      endfunction

      static function fisr_pkg::fp_type rsqrt_approx(fisr_pkg::fp_type n);
         fisr_pkg::fp_type x2, y, t;
         x2 = fmul(n, fisr_pkg::ONE_HALF);
         y  = fisr_pkg::SEED_MAGIC - (n >> 1);
         for (int k = 0; k < STEPS; k++) begin
            t = fmul(x2, y);
            t = fmul(t, y);
            t = fsub(fisr_pkg::THREE_HALF, t);
            y = fmul(y, t);
         end
         if (is_nan(y)) y = fisr_pkg::CANON_NAN;
         return y;
      endfunction

      function void note_input(fisr_pkg::fp_type n);
         pending_q.push_back(rsqrt_approx(n));
      endfunction

      function void check_result(fisr_pkg::fp_type got);
         fisr_pkg::fp_type want;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending_q.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("result_bits mismatch: exp %h got %h", want, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_number_bits = '0;
   logic        rsp_valid;
   logic [31:0] rsp_result_bits;

   rsqrt_scoreboard sb = new();
   int idle_cycles = 0;

   always #5 clock = ~clock;

   fast_inverse_sqrt_float #(.NEWTON_STEPS(STEPS)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_number_bits(req_number_bits),
      .rsp_valid(rsp_valid), .rsp_result_bits(rsp_result_bits)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (start && !busy) sb.note_input(req_number_bits);
         if (rsp_valid) sb.check_result(rsp_result_bits);
         if (idle_cycles >= STALL_MAX) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // one transaction; start stays high across back-to-back items
   task automatic send_number(input logic [31:0] n);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_number_bits = n;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_number();
      unique case ($urandom_range(0, 5))
         0: return $urandom();
         1: return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom())};
         2: return {1'b0, 8'($urandom_range(100, 154)), 23'($urandom())};
         3: return {1'($urandom()), 8'd0, 23'($urandom())};
         4: return {1'($urandom()), 8'hFF, 23'($urandom_range(0, 3) == 0 ? 0 : $urandom())};
         default: return {1'b0, 8'($urandom_range(200, 254)), 23'($urandom())};
      endcase
   endfunction

   logic [31:0] directed[$] = '{
      32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
      32'hFF800001, 32'h7FFFFFFF, 32'h3F800000, 32'h40800000, 32'h00000001,
      32'h00000002, 32'h007FFFFF, 32'h00800000, 32'h7F7FFFFF, 32'hFFFFFFFF,
      32'h3F800001, 32'hAAAAAAAA, 32'h55555555, 32'hBF800000, 32'h3E800000
   };

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed[i]) send_number(directed[i]);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 2) begin
            start = 1'b0;
            while (sb.pending_q.size() != 0) @(negedge clock);
         end
         send_number(random_number());
      end
      start = 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule

>>> fast_inverse_sqrt_float.f
rtl/fisr_pkg.sv
rtl/fisr_fmul.sv
rtl/fisr_fsub.sv
rtl/fisr_newton.sv
rtl/fast_inverse_sqrt_float.sv
rtl/fisr_checker.sv
dv/fast_inverse_sqrt_float_tb.sv
